@@ src/rhit_pkg.sv @@
// Package for the refcounted hash intern table: payload structs, command and status codes,
// default sizes. No dependencies.
package rhit_pkg;

  localparam int BKT_BITS_DEF    = 4;
  localparam int SLOT_BITS_DEF   = 4;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int TAG_BITS        = 32;

  localparam logic [2:0] CMD_INTERN = 3'd0;
  localparam logic [2:0] CMD_ADD    = 3'd1;
  localparam logic [2:0] CMD_DROP   = 3'd2;
  localparam logic [2:0] CMD_READ   = 3'd3;
  localparam logic [2:0] CMD_CMP    = 3'd4;
  localparam logic [2:0] CMD_CLEAR  = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_SATURATED = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [63:0] hash_word0;
    logic [63:0] hash_word1;
    logic [63:0] hash_word2;
    logic [63:0] hash_word3;
    logic        ref_valid;
    logic [7:0]  ref_index;
  } in_item_t;

  typedef struct packed {
    logic        result_valid;
    logic [7:0]  result_index;
    logic [63:0] read_word0;
    logic [63:0] read_word1;
    logic [63:0] read_word2;
    logic [63:0] read_word3;
    logic        same;
    logic [1:0]  status;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    in_item_t    item;
    logic        hash_zero;
  } job_t;

endpackage

@@ src/refcounted_hash_intern_table.sv @@
// Refcounted hash intern table, top level. Depends on rhit_pkg, rhit_front, rhit_back.
// Clear, unused codes, null hashes and dead references skip evaluation and write-back; read,
// compare, saturated add and underflowing drop skip write-back. Intern scans the bucket's
// occupied slots in order, stopping at a hit. A new item is taken only once the last result is
// in the result register; the two-entry input queue and the result register let both sides
// stall independently. Synchronous active-low reset clears fill counts and queues.
module refcounted_hash_intern_table #(
  parameter int BKT_BITS    = rhit_pkg::BKT_BITS_DEF,
  parameter int SLOT_BITS   = rhit_pkg::SLOT_BITS_DEF,
  parameter int COUNT_BITS  = rhit_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  rhit_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output rhit_pkg::out_item_t out_item
);

  logic           job_valid, job_take;
  rhit_pkg::job_t job;

  rhit_front u_front (
    .clk, .rst_n, .in_push(push), .in_full(full), .in_data(in_item),
    .job_valid, .job, .job_take
  );

  rhit_back #(.BKT_BITS(BKT_BITS), .SLOT_BITS(SLOT_BITS), .COUNT_BITS(COUNT_BITS))
  u_back (
    .clk, .rst_n, .job_valid, .job, .job_take,
    .out_empty(empty), .out_pop(pop), .out_data(out_item)
  );

endmodule

@@ src/rhit_front.sv @@
// Front part: accepts input items, classifies them and holds them in a two-entry queue.
// Depends on rhit_pkg.
module rhit_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  rhit_pkg::in_item_t in_data,
  output logic              job_valid,
  output rhit_pkg::job_t    job,
  input  logic              job_take
);

  rhit_pkg::job_t q_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           do_push, do_pop;
  rhit_pkg::job_t nj;

  assign in_full   = cnt_r == 2'd2;
  assign job_valid = cnt_r != 2'd0;
  assign job       = q_r[rp_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = job_take && job_valid;

  always_comb begin
    nj.item      = in_data;
    nj.hash_zero = (in_data.hash_word0 | in_data.hash_word1 | in_data.hash_word2 |
                    in_data.hash_word3) == 64'd0;
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= nj;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

@@ src/rhit_back.sv @@
// Back part: slot memories, bucket fill counts and the sequencer that executes commands.
// Depends on rhit_pkg.
module rhit_back #(
  parameter int BKT_BITS    = rhit_pkg::BKT_BITS_DEF,
  parameter int SLOT_BITS   = rhit_pkg::SLOT_BITS_DEF,
  parameter int COUNT_BITS  = rhit_pkg::COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  rhit_pkg::job_t     job,
  output logic               job_take,
  output logic               out_empty,
  input  logic               out_pop,
  output rhit_pkg::out_item_t out_data
);

  localparam int NB  = 1 << BKT_BITS;
  localparam int PB  = BKT_BITS + SLOT_BITS;
  localparam int NT  = 1 << PB;
  localparam logic [COUNT_BITS-1:0] CTOP = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {S_IDLE, S_RD, S_EVAL, S_WB, S_OUT} state_t;

  logic [255:0]                  hash_mem [NT];
  logic [rhit_pkg::TAG_BITS-1:0] tag_mem  [NT];
  logic [COUNT_BITS-1:0]         cnt_mem  [NT];
  logic [SLOT_BITS:0]            fill_r   [NB];

  state_t                  state_r;
  rhit_pkg::job_t          j_r;
  logic [BKT_BITS-1:0]     bkt_r;
  logic [SLOT_BITS:0]      idx_r;
  logic [SLOT_BITS:0]      fill_v_r;
  logic                    hf_r;
  logic [SLOT_BITS-1:0]    fs_r;
  logic [255:0]            rh_r;
  logic [rhit_pkg::TAG_BITS-1:0] rt_r;
  logic [COUNT_BITS-1:0]   rc_r;
  logic [PB-1:0]           wpos_r;
  logic                    we_h_r, we_c_r;
  logic [COUNT_BITS-1:0]   wc_r;
  rhit_pkg::out_item_t     o_r;
  rhit_pkg::out_item_t     res_r;
  logic                    full_r;

  logic [255:0]            jh;
  logic [PB-1:0]           rpos;
  logic [BKT_BITS-1:0]     rb;
  logic [SLOT_BITS-1:0]    rs;
  logic                    rok;

  assign jh = {j_r.item.hash_word3, j_r.item.hash_word2, j_r.item.hash_word1,
               j_r.item.hash_word0};
  assign rs  = j_r.item.ref_index[SLOT_BITS-1:0];
  assign rb  = BKT_BITS'(j_r.item.ref_index >> SLOT_BITS);
  assign rok = j_r.item.ref_valid && ({1'b0, rs} < fill_r[rb]);
  assign rpos = (j_r.item.command == rhit_pkg::CMD_INTERN) ?
                {bkt_r, idx_r[SLOT_BITS-1:0]} : {rb, rs};

  assign out_empty = !full_r;
  assign out_data  = res_r;
  assign job_take  = state_r == S_IDLE && job_valid;

  always_ff @(posedge clk) begin
    rh_r <= hash_mem[rpos];
    rt_r <= tag_mem[rpos];
    rc_r <= cnt_mem[rpos];
    if (we_h_r) begin
      hash_mem[wpos_r] <= jh;
      tag_mem[wpos_r]  <= jh[rhit_pkg::TAG_BITS-1:0];
    end
    if (we_c_r) cnt_mem[wpos_r] <= wc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      full_r  <= 1'b0;
      we_h_r  <= 1'b0;
      we_c_r  <= 1'b0;
      for (int b = 0; b < NB; b++) fill_r[b] <= '0;
    end else begin
      we_h_r <= 1'b0;
      we_c_r <= 1'b0;
      if (out_pop && full_r) full_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            j_r   <= job;
            bkt_r <= job.item.hash_word0[63 -: BKT_BITS];
            idx_r <= '0;
            hf_r  <= 1'b0;
            fs_r  <= '0;
            o_r   <= '0;
            fill_v_r <= fill_r[job.item.hash_word0[63 -: BKT_BITS]];
            state_r <= S_RD;
          end
        end
        S_RD: begin
          case (j_r.item.command)
            rhit_pkg::CMD_INTERN: begin
              if (j_r.hash_zero) state_r <= S_OUT;
              else if (idx_r < fill_v_r) state_r <= S_EVAL;
              else if (hf_r) begin
                wpos_r <= {bkt_r, fs_r};
                we_h_r <= 1'b1; we_c_r <= 1'b1;
                wc_r   <= COUNT_BITS'(1);
                o_r.result_valid <= 1'b1;
                o_r.result_index <= 8'({bkt_r, fs_r});
                state_r <= S_WB;
              end else if (fill_v_r[SLOT_BITS]) begin
                o_r.status <= rhit_pkg::ST_FULL;
                state_r <= S_OUT;
              end else begin
                wpos_r <= {bkt_r, fill_v_r[SLOT_BITS-1:0]};
                we_h_r <= 1'b1; we_c_r <= 1'b1;
                wc_r   <= COUNT_BITS'(1);
                fill_r[bkt_r] <= fill_v_r + 1'b1;
                o_r.result_valid <= 1'b1;
                o_r.result_index <= 8'({bkt_r, fill_v_r[SLOT_BITS-1:0]});
                state_r <= S_WB;
              end
            end
            rhit_pkg::CMD_ADD, rhit_pkg::CMD_DROP, rhit_pkg::CMD_READ: begin
              state_r <= rok ? S_EVAL : S_OUT;
            end
            rhit_pkg::CMD_CMP: begin
              if (!j_r.item.ref_valid) begin
                o_r.same <= j_r.hash_zero;
                state_r <= S_OUT;
              end else state_r <= rok ? S_EVAL : S_OUT;
            end
            rhit_pkg::CMD_CLEAR: begin
              for (int b = 0; b < NB; b++) fill_r[b] <= '0;
              state_r <= S_OUT;
            end
            default: state_r <= S_OUT;
          endcase
        end
        S_EVAL: begin
          case (j_r.item.command)
            rhit_pkg::CMD_INTERN: begin
              if (rt_r == jh[rhit_pkg::TAG_BITS-1:0] && rh_r == jh) begin
                o_r.result_valid <= 1'b1;
                o_r.result_index <= 8'({bkt_r, idx_r[SLOT_BITS-1:0]});
                if (rc_r == CTOP) begin
                  o_r.status <= rhit_pkg::ST_SATURATED;
                  state_r <= S_OUT;
                end else begin
                  wpos_r <= {bkt_r, idx_r[SLOT_BITS-1:0]};
                  we_c_r <= 1'b1;
                  wc_r   <= rc_r + 1'b1;
                  state_r <= S_WB;
                end
              end else begin
                if (!hf_r && rc_r == '0) begin
                  hf_r <= 1'b1;
                  fs_r <= idx_r[SLOT_BITS-1:0];
                end
                idx_r <= idx_r + 1'b1;
                state_r <= S_RD;
              end
            end
            rhit_pkg::CMD_ADD: begin
              if (rc_r == CTOP) begin
                o_r.status <= rhit_pkg::ST_SATURATED;
                state_r <= S_OUT;
              end else begin
                wpos_r <= rpos; we_c_r <= 1'b1; wc_r <= rc_r + 1'b1;
                state_r <= S_WB;
              end
            end
            rhit_pkg::CMD_DROP: begin
              if (rc_r == '0) begin
                o_r.status <= rhit_pkg::ST_UNDERFLOW;
                state_r <= S_OUT;
              end else begin
                wpos_r <= rpos; we_c_r <= 1'b1; wc_r <= rc_r - 1'b1;
                state_r <= S_WB;
              end
            end
            rhit_pkg::CMD_READ: begin
              o_r.read_word0 <= rh_r[63:0];
              o_r.read_word1 <= rh_r[127:64];
              o_r.read_word2 <= rh_r[191:128];
              o_r.read_word3 <= rh_r[255:192];
              state_r <= S_OUT;
            end
            rhit_pkg::CMD_CMP: begin
              o_r.same <= rh_r == jh;
              state_r <= S_OUT;
            end
            default: state_r <= S_OUT;
          endcase
        end
        S_WB: state_r <= S_OUT;
        S_OUT: begin
          if (!full_r || out_pop) begin
            res_r   <= o_r;
            full_r  <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
